@@ sv/ufm_pkg.sv @@
// Shared widths, codes and the control program of the disjoint-set sequencer.
package ufm_pkg;

  localparam int MAX_NODES_DEF = 1024;
  localparam int OP_W = 2;
  localparam int ID_W = 11;
  localparam int SIZE_W = 11;
  localparam int SUM_W = 20;
  localparam int STEP_W = 4;

  localparam logic [OP_W-1:0] OP_UNION = 2'd0;
  localparam logic [OP_W-1:0] OP_MOVE  = 2'd1;
  localparam logic [OP_W-1:0] OP_QUERY = 2'd2;

  typedef logic [STEP_W-1:0] step_t;

  localparam step_t S_IDLE     = 4'd0;
  localparam step_t S_UP_A     = 4'd1;
  localparam step_t S_COMP_A   = 4'd2;
  localparam step_t S_TAKE_A   = 4'd3;
  localparam step_t S_UP_B     = 4'd4;
  localparam step_t S_COMP_B   = 4'd5;
  localparam step_t S_TAKE_B   = 4'd6;
  localparam step_t S_FETCH    = 4'd7;
  localparam step_t S_UPDATE   = 4'd8;
  localparam step_t S_MOVE_OUT = 4'd9;
  localparam step_t S_READ_Q   = 4'd10;
  localparam step_t S_EMIT     = 4'd11;

  // Datapath operation of one step.
  typedef enum logic [3:0] {
    M_NONE,
    M_CLIMB,
    M_COMPRESS,
    M_TAKE_A,
    M_TAKE_B,
    M_HOLD_A,
    M_UPDATE,
    M_MOVE_OUT,
    M_EMIT
  } mop_t;

  // Jump condition; when false the step counter advances by one.
  typedef enum logic [2:0] {
    C_SEQ,
    C_ALWAYS,
    C_WAIT,
    C_NOT_ROOT,
    C_NOT_DONE,
    C_IS_QUERY,
    C_SAME_ROOT,
    C_IS_UNION
  } cond_t;

  // Which root the size and sum stores read.
  typedef enum logic {
    SEL_RA,
    SEL_RB
  } rsel_t;

  typedef struct packed {
    logic  idle;
    mop_t  mop;
    rsel_t rsel;
    cond_t cond;
    step_t target;
  } uword_t;

  typedef struct packed {
    logic go;
    logic not_root;
    logic not_done;
    logic is_query;
    logic same_root;
    logic is_union;
  } ustat_t;

  function automatic uword_t ucode(input step_t step);
    uword_t w;
    w = '{idle: 1'b0, mop: M_NONE, rsel: SEL_RA, cond: C_ALWAYS, target: S_IDLE};
    case (step)
      S_IDLE:     w = '{1'b1, M_NONE,     SEL_RA, C_WAIT,      S_IDLE};
      S_UP_A:     w = '{1'b0, M_CLIMB,    SEL_RA, C_NOT_ROOT,  S_UP_A};
      S_COMP_A:   w = '{1'b0, M_COMPRESS, SEL_RA, C_NOT_DONE,  S_COMP_A};
      S_TAKE_A:   w = '{1'b0, M_TAKE_A,   SEL_RA, C_IS_QUERY,  S_READ_Q};
      S_UP_B:     w = '{1'b0, M_CLIMB,    SEL_RA, C_NOT_ROOT,  S_UP_B};
      S_COMP_B:   w = '{1'b0, M_COMPRESS, SEL_RA, C_NOT_DONE,  S_COMP_B};
      S_TAKE_B:   w = '{1'b0, M_TAKE_B,   SEL_RA, C_SAME_ROOT, S_IDLE};
      S_FETCH:    w = '{1'b0, M_HOLD_A,   SEL_RB, C_SEQ,       S_IDLE};
      S_UPDATE:   w = '{1'b0, M_UPDATE,   SEL_RB, C_IS_UNION,  S_IDLE};
      S_MOVE_OUT: w = '{1'b0, M_MOVE_OUT, SEL_RA, C_ALWAYS,    S_IDLE};
      S_READ_Q:   w = '{1'b0, M_NONE,     SEL_RA, C_SEQ,       S_IDLE};
      S_EMIT:     w = '{1'b0, M_EMIT,     SEL_RA, C_ALWAYS,    S_IDLE};
      default:    w = '{1'b0, M_NONE,     SEL_RA, C_ALWAYS,    S_IDLE};
    endcase
    return w;
  endfunction

endpackage

@@ sv/ufm_seq.sv @@
// Step counter and control store of the disjoint-set sequencer.
module ufm_seq
  import ufm_pkg::*;
(
  input  logic   clk,
  input  logic   rst,
  input  ustat_t stat,
  output uword_t ctl
);

  step_t step;
  step_t step_next;
  logic  taken;

  assign ctl = ucode(step);

  always_comb begin
    case (ctl.cond)
      C_SEQ:       taken = 1'b0;
      C_ALWAYS:    taken = 1'b1;
      C_WAIT:      taken = !stat.go;
      C_NOT_ROOT:  taken = stat.not_root;
      C_NOT_DONE:  taken = stat.not_done;
      C_IS_QUERY:  taken = stat.is_query;
      C_SAME_ROOT: taken = stat.same_root;
      C_IS_UNION:  taken = stat.is_union;
      default:     taken = 1'b1;
    endcase
    step_next = taken ? ctl.target : step + step_t'(1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step <= S_IDLE;
    end else begin
      step <= step_next;
    end
  end

endmodule

@@ sv/union_find_with_move.sv @@
// Top level of the disjoint-set store with union, move and query.
//
// Disjoint-set store over elements 1..node_count. Each element hangs under a
// virtual root (node_count+i) that alone carries set size and element sum.
// An item is taken when start is high and busy is low; busy stays high until
// the item is finished. A query gives one result: result_valid is high for
// exactly one cycle with set_size and set_sum, and the receiver cannot hold
// it off, so it must take it in that cycle. Union and move give no result,
// nor does any item with an id it uses outside 1..node_count or opcode 3.
// An item walks from its first id up the parent links to the root, one link
// per cycle, then walks the path again pointing every node at the root; a
// union or move does the same from its second id, then merges or relinks
// unless both ids already share a root. An ignored item is dropped at its
// transfer edge and the block stays idle. The walk is set by the single
// read port of the parent store. After reset and after every node_count
// write the stores are rebuilt by a sweep over slots 1..2*node_count, busy
// high throughout.
module union_find_with_move
  import ufm_pkg::*;
#(
  parameter int MAX_NODES = MAX_NODES_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_write,
  input  logic [ID_W-1:0]   node_count,
  input  logic              start,
  input  logic [OP_W-1:0]   opcode,
  input  logic [ID_W-1:0]   first_element,
  input  logic [ID_W-1:0]   second_element,
  output logic              busy,
  output logic              result_valid,
  output logic [SIZE_W-1:0] set_size,
  output logic [SUM_W-1:0]  set_sum
);

  localparam int DEPTH = 2 * MAX_NODES + 1;
  localparam int NW = $clog2(MAX_NODES + 1);
  localparam int AW = $clog2(DEPTH);
  localparam int CW = (ID_W > AW) ? ID_W : AW;

  // Control program and its status inputs
  uword_t ctl;
  ustat_t stat;

  // Element count and rebuild sweep
  logic [NW-1:0] nc;
  logic          clearing;
  logic [AW-1:0] clr_idx;
  logic [AW-1:0] nc_a;
  logic [AW-1:0] two_n;

  // Item and walk registers
  logic [OP_W-1:0] op;
  logic [AW-1:0]   elem_a, elem_b;
  logic [AW-1:0]   cur, cur_next;
  logic [AW-1:0]   origin, origin_next;
  logic [AW-1:0]   root, root_next;
  logic [AW-1:0]   ra, ra_next;
  logic [AW-1:0]   rb, rb_next;
  logic [SIZE_W-1:0] sa, sa_next;
  logic [SUM_W-1:0]  ua, ua_next;

  // Stores and their registered read data
  logic [AW-1:0]     parent_mem [DEPTH];
  logic [SIZE_W-1:0] size_mem [DEPTH];
  logic [SUM_W-1:0]  sum_mem [DEPTH];
  logic [AW-1:0]     pdata;
  logic [SIZE_W-1:0] sz_q;
  logic [SUM_W-1:0]  sum_q;

  // Write ports
  logic              pw_en;
  logic [AW-1:0]     pw_addr, pw_data;
  logic              rw_en;
  logic [AW-1:0]     rw_addr, rr_addr;
  logic [SIZE_W-1:0] rw_size;
  logic [SUM_W-1:0]  rw_sum;

  logic accept, a_ok, b_ok, op_ok;
  logic [CW-1:0] cfg_v;
  logic [NW-1:0] nc_w;
  logic [AW-1:0] big, small_root;

  ufm_seq u_seq (
    .clk  (clk),
    .rst  (rst),
    .stat (stat),
    .ctl  (ctl)
  );

  assign busy   = clearing || !ctl.idle;
  assign accept = start && !busy;
  assign nc_a   = AW'(nc);
  assign two_n  = AW'({nc, 1'b0});

  // Range checks on the incoming ids
  assign a_ok = (first_element != '0) && (CW'(first_element) <= CW'(nc));
  assign b_ok = (second_element != '0) && (CW'(second_element) <= CW'(nc));
  always_comb begin
    case (opcode)
      OP_UNION: op_ok = a_ok && b_ok;
      OP_MOVE:  op_ok = a_ok && b_ok;
      OP_QUERY: op_ok = a_ok;
      default:  op_ok = 1'b0;
    endcase
  end

  assign stat.go        = accept && op_ok;
  assign stat.not_root  = pdata != cur;
  assign stat.not_done  = cur != root;
  assign stat.is_query  = op == OP_QUERY;
  assign stat.same_root = root == ra;
  assign stat.is_union  = op == OP_UNION;

  // Saturate the written element count into 1..MAX_NODES
  assign cfg_v = CW'(node_count);
  always_comb begin
    if (cfg_v == '0) begin
      nc_w = NW'(1);
    end else if (cfg_v > CW'(MAX_NODES)) begin
      nc_w = NW'(MAX_NODES);
    end else begin
      nc_w = NW'(cfg_v);
    end
  end

  // Larger root wins a union; on a tie the first set's root stays on top
  assign big        = (sa < sz_q) ? rb : ra;
  assign small_root = (sa < sz_q) ? ra : rb;

  always_comb begin
    cur_next    = cur;
    origin_next = origin;
    root_next   = root;
    ra_next     = ra;
    rb_next     = rb;
    sa_next     = sa;
    ua_next     = ua;
    pw_en       = 1'b0;
    pw_addr     = cur;
    pw_data     = root;
    rw_en       = 1'b0;
    rw_addr     = ra;
    rw_size     = sz_q;
    rw_sum      = sum_q;
    rr_addr     = (ctl.rsel == SEL_RB) ? rb : ra;

    if (clearing) begin
      // Rebuild: element j under n+j, each virtual root alone with size 1
      pw_en   = 1'b1;
      pw_addr = clr_idx;
      pw_data = (clr_idx <= nc_a) ? nc_a + clr_idx : clr_idx;
      rw_en   = 1'b1;
      rw_addr = clr_idx;
      rw_size = SIZE_W'(1);
      rw_sum  = SUM_W'(clr_idx - nc_a);
    end else begin
      case (ctl.mop)
        M_NONE: begin
          if (accept) begin
            cur_next    = AW'(first_element);
            origin_next = AW'(first_element);
          end
        end
        M_CLIMB: begin
          if (pdata != cur) begin
            cur_next = pdata;
          end else begin
            root_next = cur;
            cur_next  = origin;
          end
        end
        M_COMPRESS: begin
          // Point the walked node straight at the root and advance
          if (cur != root) begin
            pw_en    = 1'b1;
            pw_addr  = cur;
            pw_data  = root;
            cur_next = pdata;
          end
        end
        M_TAKE_A: begin
          ra_next = root;
          if (op != OP_QUERY) begin
            cur_next    = elem_b;
            origin_next = elem_b;
          end
        end
        M_TAKE_B: begin
          rb_next = root;
        end
        M_HOLD_A: begin
          sa_next = sz_q;
          ua_next = sum_q;
        end
        M_UPDATE: begin
          pw_en = 1'b1;
          rw_en = 1'b1;
          if (op == OP_UNION) begin
            pw_addr = small_root;
            pw_data = big;
            rw_addr = big;
            rw_size = sa + sz_q;
            rw_sum  = ua + sum_q;
          end else begin
            // Move: relink the element and grow the target set
            pw_addr = elem_a;
            pw_data = rb;
            rw_addr = rb;
            rw_size = sz_q + SIZE_W'(1);
            rw_sum  = sum_q + SUM_W'(elem_a);
          end
        end
        M_MOVE_OUT: begin
          // Shrink the set the element left
          rw_en   = 1'b1;
          rw_addr = ra;
          rw_size = sa - SIZE_W'(1);
          rw_sum  = ua - SUM_W'(elem_a);
        end
        M_EMIT: begin
        end
        default: begin
        end
      endcase
    end
  end

  // Element count and rebuild sweep; a write restarts the sweep
  always_ff @(posedge clk) begin
    if (rst) begin
      nc       <= NW'(MAX_NODES);
      clearing <= 1'b1;
      clr_idx  <= AW'(1);
    end else if (cfg_write) begin
      nc       <= nc_w;
      clearing <= 1'b1;
      clr_idx  <= AW'(1);
    end else if (clearing) begin
      if (clr_idx == two_n) begin
        clearing <= 1'b0;
      end
      clr_idx <= clr_idx + AW'(1);
    end
  end

  // Item and walk registers
  always_ff @(posedge clk) begin
    if (accept) begin
      op     <= opcode;
      elem_a <= AW'(first_element);
      elem_b <= AW'(second_element);
    end
    cur    <= cur_next;
    origin <= origin_next;
    root   <= root_next;
    ra     <= ra_next;
    rb     <= rb_next;
    sa     <= sa_next;
    ua     <= ua_next;
  end

  // Parent store: the read follows the next walk address, with the write
  // of the same edge passed through so the walk never sees a stale link
  always_ff @(posedge clk) begin
    if (pw_en) begin
      parent_mem[pw_addr] <= pw_data;
    end
    if (pw_en && (pw_addr == cur_next)) begin
      pdata <= pw_data;
    end else begin
      pdata <= parent_mem[cur_next];
    end
  end

  // Size and sum stores, kept at virtual roots only
  always_ff @(posedge clk) begin
    if (rw_en) begin
      size_mem[rw_addr] <= rw_size;
      sum_mem[rw_addr]  <= rw_sum;
    end
    sz_q  <= size_mem[rr_addr];
    sum_q <= sum_mem[rr_addr];
  end

  // Query result: one-cycle strobe, data straight from the read registers
  assign result_valid = ctl.mop == M_EMIT;
  assign set_size     = sz_q;
  assign set_sum      = sum_q;

endmodule

@@ sv/ufm_check.sv @@
// Port-level checker for the disjoint-set store, bound to the top level.
module ufm_check
  import ufm_pkg::*;
(
  input logic              clk,
  input logic              rst,
  input logic              cfg_write,
  input logic [ID_W-1:0]   node_count,
  input logic              start,
  input logic [OP_W-1:0]   opcode,
  input logic [ID_W-1:0]   first_element,
  input logic [ID_W-1:0]   second_element,
  input logic              busy,
  input logic              result_valid,
  input logic [SIZE_W-1:0] set_size,
  input logic [SUM_W-1:0]  set_sum
);

  // A result only ever appears while an item is in hand
  a_result_busy: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> busy)
    else $error("result transfer while not busy");

  // A result lasts one cycle and ends the item
  a_result_single: assert property (@(posedge clk) disable iff (rst)
    result_valid |=> !result_valid && !$past(start && !busy))
    else $error("result strobe held or item taken during result");

  // Reset and every count write start the rebuild sweep
  a_rebuild: assert property (@(posedge clk)
    (rst || cfg_write) |=> busy)
    else $error("no rebuild after reset or count write");

  // A set always holds at least the queried element
  a_nonempty: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (set_size != '0) && (set_sum != '0))
    else $error("empty set reported");

endmodule

bind union_find_with_move ufm_check u_check (.*);

@@ bench/tb_union_find_with_move.sv @@
// Self-checking bench for the disjoint-set store with union, move and query.
`timescale 1ns / 1ps

module tb_union_find_with_move;
  import ufm_pkg::*;

  // Opcode 3 has no meaning; the block must drop it without a result.
  localparam logic [OP_W-1:0] OP_SPARE = 2'd3;

  localparam int LINK_DEPTH    = 2 * MAX_NODES_DEF + 1;
  // Extra wait at the end of a phase, once busy has dropped and results are in.
  localparam int SETTLE_CYCLES = 64;
  // Upper bound on the wait for busy and results at the end of a phase.
  localparam int SETTLE_LIMIT  = 20000;

  typedef struct packed {
    logic [OP_W-1:0] op;
    logic [ID_W-1:0] first;
    logic [ID_W-1:0] second;
  } op_item_t;

  typedef struct packed {
    logic [SIZE_W-1:0] size;
    logic [SUM_W-1:0]  sum;
  } set_result_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              cfg_write = 1'b0;
  logic [ID_W-1:0]   node_count = ID_W'(MAX_NODES_DEF);
  logic              start = 1'b0;
  logic [OP_W-1:0]   opcode = OP_QUERY;
  logic [ID_W-1:0]   first_element = '0;
  logic [ID_W-1:0]   second_element = '0;
  logic              busy;
  logic              result_valid;
  logic [SIZE_W-1:0] set_size;
  logic [SUM_W-1:0]  set_sum;

  // Predictor state: our own copy of the link, size and sum stores.
  logic [11:0]       link_tbl [LINK_DEPTH];
  logic [SIZE_W-1:0] size_tbl [LINK_DEPTH];
  logic [SUM_W-1:0]  sum_tbl  [LINK_DEPTH];
  int                nodes_in_use;

  op_item_t    pending_ops [$];
  set_result_t expected_sets [$];
  op_item_t    driven_item;
  int          idle_pct = 0;
  int          queued_count = 0;
  int          accepted_count = 0;
  int          error_count = 0;

  union_find_with_move u_dut (
    .clk            (clk),
    .rst            (rst),
    .cfg_write      (cfg_write),
    .node_count     (node_count),
    .start          (start),
    .opcode         (opcode),
    .first_element  (first_element),
    .second_element (second_element),
    .busy           (busy),
    .result_valid   (result_valid),
    .set_size       (set_size),
    .set_sum        (set_sum)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // Hold reset once at the start, then release it for the rest of the run.
  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
  end

  // Generous ceiling: even a stuck block cannot keep the run going past this.
  initial begin
    #(4_000_000);
    $display("union_find_with_move test failed");
    $finish;
  end

  task automatic report_mismatch(input string what);
    $display("MISMATCH @%0t: %s", $realtime, what);
    error_count++;
  endtask

  // Rebuild every set as a singleton under its virtual root, as the block
  // does after reset and after each node_count write. Saturate the count.
  function automatic void rebuild_sets(input logic [ID_W-1:0] value);
    int i;
    int count;
    count = int'(value);
    if (count < 1) count = 1;
    if (count > MAX_NODES_DEF) count = MAX_NODES_DEF;
    for (i = 0; i < LINK_DEPTH; i++) begin
      link_tbl[i] = '0;
      size_tbl[i] = '0;
      sum_tbl[i]  = '0;
    end
    nodes_in_use = count;
    for (i = 1; i <= count; i++) begin
      link_tbl[i]         = 12'(count + i);
      link_tbl[count + i] = 12'(count + i);
      size_tbl[count + i] = SIZE_W'(1);
      sum_tbl[count + i]  = SUM_W'(i);
    end
  endfunction

  // Keep every walk inside the stores; a stray link falls back to slot 0.
  function automatic int clip_index(input int v);
    return (v >= 0 && v < LINK_DEPTH) ? v : 0;
  endfunction

  // Walk to the root, then point every node on the path straight at it.
  function automatic int find_root_of(input int origin);
    int root;
    int walk;
    int nxt;
    int steps;
    root = clip_index(origin);
    for (steps = 0; steps < LINK_DEPTH && int'(link_tbl[root]) != root; steps++)
      root = clip_index(int'(link_tbl[root]));
    walk = clip_index(origin);
    for (steps = 0; steps < LINK_DEPTH && walk != root; steps++) begin
      nxt = clip_index(int'(link_tbl[walk]));
      link_tbl[walk] = 12'(root);
      walk = nxt;
    end
    return root;
  endfunction

  function automatic bit id_in_use(input logic [ID_W-1:0] id);
    return id >= 1 && int'(id) <= nodes_in_use;
  endfunction

  // Advance the predictor by one transferred item; queue a result for a query.
  function automatic void apply_set_op(input op_item_t it);
    int ra;
    int rb;
    int t;
    set_result_t res;
    if (it.op == OP_QUERY) begin
      if (!id_in_use(it.first)) return;
      ra = find_root_of(int'(it.first));
      res.size = size_tbl[ra];
      res.sum  = sum_tbl[ra];
      expected_sets.push_back(res);
      return;
    end
    if (it.op == OP_SPARE || !id_in_use(it.first) || !id_in_use(it.second)) return;
    ra = find_root_of(int'(it.first));
    rb = find_root_of(int'(it.second));
    // Same set: nothing to merge or move.
    if (ra == rb) return;
    if (it.op == OP_UNION) begin
      // Smaller set joins the larger; on a tie the second set's root joins.
      if (size_tbl[ra] < size_tbl[rb]) begin
        t  = ra;
        ra = rb;
        rb = t;
      end
      size_tbl[ra] = size_tbl[ra] + size_tbl[rb];
      sum_tbl[ra]  = sum_tbl[ra] + sum_tbl[rb];
      link_tbl[rb] = 12'(ra);
    end else begin
      size_tbl[rb] = size_tbl[rb] + SIZE_W'(1);
      size_tbl[ra] = size_tbl[ra] - SIZE_W'(1);
      sum_tbl[rb]  = sum_tbl[rb] + SUM_W'(it.first);
      sum_tbl[ra]  = sum_tbl[ra] - SUM_W'(it.first);
      link_tbl[int'(it.first)] = 12'(rb);
    end
  endfunction

  task automatic queue_op(input logic [OP_W-1:0] op, input int a, input int b);
    op_item_t it;
    it.op     = op;
    it.first  = ID_W'(a);
    it.second = ID_W'(b);
    pending_ops.push_back(it);
    queued_count++;
  endtask

  // Mostly ids in use, with the ends of the range and some raw noise that
  // reaches every bit of the field. Large stores crowd into a low window so
  // that sets actually grow.
  function automatic int pick_id();
    int r;
    r = $urandom_range(99);
    if (r < 8)  return $urandom_range(2047);
    if (r < 12) return 1;
    if (r < 16) return nodes_in_use;
    if (nodes_in_use > 64 && r < 70) return $urandom_range(32, 1);
    return $urandom_range(nodes_in_use, 1);
  endfunction

  task automatic queue_random_ops(input int count);
    int n;
    int r;
    logic [OP_W-1:0] op;
    for (n = 0; n < count; n++) begin
      r = $urandom_range(99);
      if (r < 38)      op = OP_UNION;
      else if (r < 62) op = OP_MOVE;
      else if (r < 95) op = OP_QUERY;
      else             op = OP_SPARE;
      queue_op(op, pick_id(), (op == OP_QUERY) ? $urandom_range(2047) : pick_id());
    end
  endtask

  // Wait until every queued item has been transferred, the block has gone
  // quiet and every query has come back. Anything still owed is a failure.
  task automatic settle_block();
    int waited;
    waited = 0;
    do @(negedge clk); while (accepted_count != queued_count);
    while ((busy || expected_sets.size() != 0) && waited < SETTLE_LIMIT) begin
      @(negedge clk);
      waited++;
    end
    repeat (SETTLE_CYCLES) @(negedge clk);
    if (expected_sets.size() != 0) begin
      report_mismatch($sformatf("%0d query results never arrived", expected_sets.size()));
      expected_sets.delete();
    end
  endtask

  // Write node_count while the block is idle, rebuild our copy at the same
  // edge, then wait out the clearing sweep.
  task automatic write_node_count(input int value);
    @(posedge clk);
    cfg_write  <= 1'b1;
    node_count <= ID_W'(value);
    @(posedge clk);
    cfg_write  <= 1'b0;
    rebuild_sets(ID_W'(value));
    repeat (2) @(negedge clk);
    while (busy) @(negedge clk);
  endtask

  // Driver: offer the next pending item whenever the previous one has been
  // transferred or nothing is on offer, idling at random as the phase says.
  always @(posedge clk) begin : op_driver
    op_item_t nxt;
    logic     advance;
    if (rst) begin
      start <= 1'b0;
    end else begin
      advance = !start;
      if (start && !busy) begin
        apply_set_op(driven_item);
        accepted_count++;
        advance = 1'b1;
      end
      if (advance) begin
        if (pending_ops.size() != 0 && $urandom_range(99) >= idle_pct) begin
          nxt            = pending_ops.pop_front();
          driven_item    = nxt;
          start          <= 1'b1;
          opcode         <= nxt.op;
          first_element  <= nxt.first;
          second_element <= nxt.second;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // Monitor: every strobed result must match the oldest query still owed.
  always @(posedge clk) begin : result_monitor
    set_result_t want;
    if (!rst && result_valid) begin
      if (expected_sets.size() == 0) begin
        report_mismatch($sformatf("result with no query owed: size %0d sum %0d",
                                  set_size, set_sum));
      end else begin
        want = expected_sets.pop_front();
        if (set_size !== want.size)
          report_mismatch($sformatf("set_size %0d, expected %0d", set_size, want.size));
        if (set_sum !== want.sum)
          report_mismatch($sformatf("set_sum %0d, expected %0d", set_sum, want.sum));
      end
    end
  end

  initial begin
    rebuild_sets(ID_W'(MAX_NODES_DEF));
    // Let reset and the clearing sweep that follows it finish.
    do @(negedge clk); while (rst || busy);

    // Reset value of node_count: ends of the range, ignored ids, spare opcode.
    idle_pct = 14;
    queue_op(OP_QUERY, 1, 0);
    queue_op(OP_QUERY, MAX_NODES_DEF, 2047);
    queue_op(OP_QUERY, 0, 5);
    queue_op(OP_QUERY, MAX_NODES_DEF + 1, 1);
    queue_op(OP_QUERY, 2047, 2047);
    queue_op(OP_UNION, 1, MAX_NODES_DEF);
    queue_op(OP_QUERY, MAX_NODES_DEF, 0);
    queue_op(OP_SPARE, 1, 2);
    queue_op(OP_UNION, 0, 5);
    queue_op(OP_MOVE, MAX_NODES_DEF, 3);
    queue_op(OP_MOVE, 3, MAX_NODES_DEF + 1);
    queue_op(OP_QUERY, 1, 0);
    queue_op(OP_QUERY, 3, 2047);
    settle_block();

    // Zero saturates to one element: everything is the same set.
    write_node_count(0);
    queue_op(OP_UNION, 1, 1);
    queue_op(OP_MOVE, 1, 1);
    queue_op(OP_QUERY, 1, 0);
    queue_op(OP_QUERY, 2, 0);
    queue_op(OP_UNION, 1, 2);
    settle_block();

    // Small store: smaller-joins-larger, tie order, move and move in place.
    write_node_count(6);
    queue_op(OP_UNION, 1, 2);
    queue_op(OP_UNION, 3, 1);
    queue_op(OP_MOVE, 2, 4);
    queue_op(OP_MOVE, 4, 2);
    queue_op(OP_UNION, 5, 6);
    queue_op(OP_UNION, 5, 1);
    queue_op(OP_QUERY, 1, 0);
    queue_op(OP_QUERY, 4, 0);
    queue_op(OP_QUERY, 6, 0);
    settle_block();

    // Random phases: light sender idling first.
    write_node_count(16);
    queue_random_ops(300);
    settle_block();

    // Above the maximum saturates to the full store.
    write_node_count(2047);
    queue_random_ops(200);
    settle_block();

    // Heavy sender idling next.
    idle_pct = 53;
    write_node_count(1);
    queue_random_ops(60);
    settle_block();

    write_node_count(40);
    queue_random_ops(280);
    settle_block();

    // Back to back, no idling at all.
    idle_pct = 0;
    write_node_count(MAX_NODES_DEF);
    queue_random_ops(60);
    settle_block();

    write_node_count(5);
    queue_random_ops(200);
    settle_block();

    if (error_count == 0) begin
      $display("union_find_with_move test passed");
    end else begin
      $display("union_find_with_move test failed");
    end
    $finish;
  end

endmodule
